// File: sv/fpm_pkg.sv
// Shared types and constants for the first pattern match finder.
`timescale 1ns / 1ps

package fpm_pkg;

    localparam int          MAX_PATTERN_DEF = 16;
    localparam longint      MAX_TEXT_DEF    = 64'd65536;
    localparam int          PAT_BYTES       = 16;
    localparam int          LEN_W           = 5;
    localparam int          POS_W           = 16;
    localparam int          CFG_IDX_W       = 2;
    localparam int          CFG_DATA_W      = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 2'd2;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] match_start;
        logic             overflow;
    } out_item_t;

    // Control shared by every cell of the row
    typedef struct packed {
        logic advance;
        logic clear;
    } cell_ctrl_t;

endpackage

// File: sv/fpm_cell.sv
// One cell of the match row: tracks whether the text so far ends in pattern[0..i].
`timescale 1ns / 1ps

module fpm_cell
    import fpm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  logic [7:0] text_byte,
    input  logic [7:0] pattern_byte,
    input  logic       prev_hit,
    output logic       hit,
    output logic       hit_now
);

    logic hit_reg;
    logic hit_next;

    // Prefix up to this cell matches if the prefix before it matched one byte ago
    assign hit_now = prev_hit && (text_byte == pattern_byte);

    always_comb
    begin
        hit_next = hit_reg;
        if (ctrl.clear)
        begin
            hit_next = 1'b0;
        end
        else if (ctrl.advance)
        begin
            hit_next = hit_now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_next;
        end
    end

    assign hit = hit_reg;

endmodule

// File: sv/first_pattern_match_finder.sv
// Top level: streaming search for the first occurrence of a 1 to 16 byte pattern.
`timescale 1ns / 1ps
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------
//  in      | input     | in_valid / in_stall | in_item_t  {text_byte, last_byte}
//  out     | output    | out_valid/out_stall | out_item_t {found, match_start, overflow}
//  cfg     | input     | cfg_we              | cfg_index, cfg_data
//
//  One text byte per cycle unless stalled; a result appears in the output
//  register in the cycle after the byte that causes it. The cell row compares the byte
//  against every pattern position at once; that single compare stage sets the rate.
//  Input stalls only while a result sits in the output register and is stalled.
//  Reset clears the row, the position and the pattern (length 1, all zeros).
//  A configuration write to the pattern low, pattern high or length index restarts the search.

module first_pattern_match_finder
    import fpm_pkg::*;
#(
    parameter int     MAX_PATTERN = MAX_PATTERN_DEF,
    parameter longint MAX_TEXT    = MAX_TEXT_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam logic [POS_W-1:0] POS_CAP =
        (MAX_TEXT - 1 > 65535) ? {POS_W{1'b1}} : POS_W'(MAX_TEXT - 1);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PATTERN);

    logic [PAT_BYTES-1:0][7:0] pattern_reg, pattern_next;
    logic [LEN_W-1:0]          length_reg, length_next;
    logic [POS_W-1:0]          position_reg, position_next;
    logic                      reported_reg, reported_next;
    logic                      saturated_reg, saturated_next;
    logic                      out_valid_reg, out_valid_next;
    out_item_t                 out_data_reg, out_data_next;

    logic                      accept;
    logic                      cfg_hit;
    logic [LEN_W-1:0]          cfg_len;
    logic [IDX_W-1:0]          last_cell;
    logic                      match;
    cell_ctrl_t                ctrl;
    logic [MAX_PATTERN-1:0]    hit;
    logic [MAX_PATTERN-1:0]    hit_now;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign cfg_hit  = cfg_we && (cfg_index == CFG_PATTERN_LOW
                               || cfg_index == CFG_PATTERN_HIGH
                               || cfg_index == CFG_PATTERN_LENGTH);

    assign ctrl.clear   = cfg_hit || (accept && in_data.last_byte);
    assign ctrl.advance = accept;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_PATTERN; gi++)
        begin : g_cell
            logic prev;
            if (gi == 0)
            begin : g_head
                assign prev = 1'b1;
            end
            else
            begin : g_body
                assign prev = hit[gi-1];
            end
            fpm_cell u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .ctrl         (ctrl),
                .text_byte    (in_data.text_byte),
                .pattern_byte (pattern_reg[gi]),
                .prev_hit     (prev),
                .hit          (hit[gi]),
                .hit_now      (hit_now[gi])
            );
        end
    endgenerate

    assign last_cell = IDX_W'(length_reg - LEN_W'(1));
    assign match     = hit_now[last_cell] && !reported_reg;

    // Clamp the written length into 1..MAX_PATTERN
    always_comb
    begin
        cfg_len = cfg_data[LEN_W-1:0];
        if (cfg_len == '0)
        begin
            cfg_len = LEN_W'(1);
        end
        else if (cfg_len > LEN_MAX)
        begin
            cfg_len = LEN_MAX;
        end
    end

    always_comb
    begin
        pattern_next   = pattern_reg;
        length_next    = length_reg;
        position_next  = position_reg;
        reported_next  = reported_reg;
        saturated_next = saturated_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;

        if (cfg_hit)
        begin
            case (cfg_index)
                CFG_PATTERN_LOW:    pattern_next[7:0]  = cfg_data;
                CFG_PATTERN_HIGH:   pattern_next[15:8] = cfg_data;
                CFG_PATTERN_LENGTH: length_next        = cfg_len;
                default:            length_next        = length_reg;
            endcase
            position_next  = '0;
            reported_next  = 1'b0;
            saturated_next = 1'b0;
        end
        else if (accept)
        begin
            if (match)
            begin
                reported_next              = 1'b1;
                out_valid_next             = 1'b1;
                out_data_next.found        = 1'b1;
                out_data_next.match_start  = position_reg + POS_W'(1)
                                             - POS_W'(length_reg);
                out_data_next.overflow     = saturated_reg;
            end
            else if (in_data.last_byte && !reported_reg)
            begin
                out_valid_next             = 1'b1;
                out_data_next.found        = 1'b0;
                out_data_next.match_start  = '0;
                out_data_next.overflow     = saturated_reg;
            end

            // Hold the position at the cap once reached
            if (position_reg >= POS_CAP)
            begin
                position_next  = POS_CAP;
                saturated_next = 1'b1;
            end
            else
            begin
                position_next = position_reg + POS_W'(1);
            end

            if (in_data.last_byte)
            begin
                position_next  = '0;
                reported_next  = 1'b0;
                saturated_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg   <= '0;
            length_reg    <= LEN_W'(1);
            position_reg  <= '0;
            reported_reg  <= 1'b0;
            saturated_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pattern_reg   <= pattern_next;
            length_reg    <= length_next;
            position_reg  <= position_next;
            reported_reg  <= reported_next;
            saturated_reg <= saturated_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: sv/fpm_checker.sv
// Port-level checks for the first pattern match finder, bound to the top level.
`timescale 1ns / 1ps

module fpm_checker
    import fpm_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_stall,
    input logic      out_valid,
    input logic      out_stall,
    input out_item_t out_data
);

    // Input only backs up behind a result that cannot leave
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a stalled result");

    // A not-found beat carries a zero start index
    a_miss_start: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.found) |-> (out_data.match_start == '0))
        else $error("not-found beat with nonzero match_start");

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
        else $error("stalled result beat changed");

    // No result appears unless a byte was taken
    a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid ##1 out_valid) |-> $past(in_valid && !in_stall))
        else $error("result beat without an accepted byte");

endmodule

bind first_pattern_match_finder fpm_checker u_fpm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
